/* rtl/pob_pkg.sv */
// ----------------------------------------------------------------------------
// pob_pkg: shared types and helpers for the palette overlay pixel blender
// Command codes, palette entry layouts and the 565 pack function.
// ----------------------------------------------------------------------------
package pob_pkg;

    localparam int MAIN_ENTRIES_DEFAULT    = 16;
    localparam int OVERLAY_ENTRIES_DEFAULT = 16;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 4;
    localparam int CHAN_W  = 8;
    localparam int SHIFT_W = 4;
    localparam int SUM_W   = 9;
    localparam int PIXEL_W = 16;

    localparam logic [CMD_W-1:0] CMD_CONVERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_MAIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_OVL  = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } main_entry_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
    } ovl_entry_t;

    localparam int MAIN_W = $bits(main_entry_t);
    localparam int OVL_W  = $bits(ovl_entry_t);

    // red carry bit drops off the top, green and blue carries spill upward
    function automatic logic [PIXEL_W-1:0] pack565(
        input logic [SUM_W-1:0] r,
        input logic [SUM_W-1:0] g,
        input logic [SUM_W-1:0] b
    );
        logic [PIXEL_W-1:0] v;
        begin
            v = {r[7:3], 11'b0} | {4'b0, g[8:2], 5'b0} | {10'b0, b[8:3]};
            return v;
        end
    endfunction

endpackage

/* rtl/pob_palette_ram.sv */
// ----------------------------------------------------------------------------
// pob_palette_ram: palette storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pob_palette_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pob_blend.sv */
// ----------------------------------------------------------------------------
// pob_blend: overlay blend and 565 pack
// Shifts main channels and adds the overlay color when enabled, then packs the result.
// ----------------------------------------------------------------------------
module pob_blend (
    input  pob_pkg::main_entry_t          main_entry,
    input  pob_pkg::ovl_entry_t           ovl_entry,
    input  logic                          overlay_enable,
    output logic [pob_pkg::PIXEL_W-1:0]   pixel
);

    logic [pob_pkg::CHAN_W-1:0] r_sh;
    logic [pob_pkg::CHAN_W-1:0] g_sh;
    logic [pob_pkg::CHAN_W-1:0] b_sh;
    logic [pob_pkg::SUM_W-1:0]  r_sum;
    logic [pob_pkg::SUM_W-1:0]  g_sum;
    logic [pob_pkg::SUM_W-1:0]  b_sum;

    always_comb
    begin
        // shifts of eight and above clear the channel
        if (ovl_entry.shift[3])
        begin
            r_sh = '0;
            g_sh = '0;
            b_sh = '0;
        end
        else
        begin
            r_sh = main_entry.r >> ovl_entry.shift[2:0];
            g_sh = main_entry.g >> ovl_entry.shift[2:0];
            b_sh = main_entry.b >> ovl_entry.shift[2:0];
        end

        if (overlay_enable)
        begin
            r_sum = {1'b0, r_sh} + {1'b0, ovl_entry.r};
            g_sum = {1'b0, g_sh} + {1'b0, ovl_entry.g};
            b_sum = {1'b0, b_sh} + {1'b0, ovl_entry.b};
        end
        else
        begin
            r_sum = {1'b0, main_entry.r};
            g_sum = {1'b0, main_entry.g};
            b_sum = {1'b0, main_entry.b};
        end

        pixel = pob_pkg::pack565(r_sum, g_sum, b_sum);
    end

endmodule

/* rtl/palette_overlay_pixel_blender.sv */
// ----------------------------------------------------------------------------
// palette_overlay_pixel_blender: indexed pixel to 565 converter
// Palette lookup with optional shifted overlay blend.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per accept: convert
//   a pixel (command 0), load a main palette entry (1) or load an overlay
//   palette entry (2). Command 3 is dropped. Loads write the palette at the
//   accept edge and give no result.
//   Output channel (out_valid/out_ready) carries pixel_565, one per convert.
//   cfg_write/cfg_data set overlay_enable; write it only while idle.
// Timing:
//   The palette read ports register the entries at the accept edge, then
//   blend and pack feed the output register, which raises out_valid.
//   One request is taken per cycle while the output is not stalled.
// Reset clears the pipeline valids and overlay_enable; palette contents are
// undefined until loaded.
// When the receiver stalls, the output register holds, the read stage fills,
// and in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module palette_overlay_pixel_blender #(
    parameter int MAIN_ENTRIES    = pob_pkg::MAIN_ENTRIES_DEFAULT,
    parameter int OVERLAY_ENTRIES = pob_pkg::OVERLAY_ENTRIES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pob_pkg::CMD_W-1:0]     command,
    input  logic [pob_pkg::INDEX_W-1:0]   pixel_index,
    input  logic [pob_pkg::INDEX_W-1:0]   overlay_index,
    input  logic [pob_pkg::CHAN_W-1:0]    red,
    input  logic [pob_pkg::CHAN_W-1:0]    green,
    input  logic [pob_pkg::CHAN_W-1:0]    blue,
    input  logic [pob_pkg::SHIFT_W-1:0]   shift_amount,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pob_pkg::PIXEL_W-1:0]   pixel_565
);

    localparam int MAIN_AW = $clog2(MAIN_ENTRIES);
    localparam int OVL_AW  = $clog2(OVERLAY_ENTRIES);
    localparam int IDX_VALS = 2 ** pob_pkg::INDEX_W;

    logic                         overlay_enable_reg;
    logic                         valid_a_reg;
    logic                         out_valid_reg;
    logic [pob_pkg::PIXEL_W-1:0]  pixel_reg;
    logic [pob_pkg::PIXEL_W-1:0]  pixel_next;

    logic                         in_accept;
    logic                         advance_a;
    logic                         is_convert;
    logic [MAIN_AW-1:0]           main_addr;
    logic [OVL_AW-1:0]            ovl_addr;
    pob_pkg::main_entry_t         main_wdata;
    pob_pkg::ovl_entry_t          ovl_wdata;
    pob_pkg::main_entry_t         main_rdata;
    pob_pkg::ovl_entry_t          ovl_rdata;

    assign advance_a  = !out_valid_reg || out_ready;
    assign in_ready   = !valid_a_reg || advance_a;
    assign in_accept  = in_valid && in_ready;
    assign is_convert = (command == pob_pkg::CMD_CONVERT);

    // index wrap by palette size, as a small constant table
    always_comb
    begin
        main_addr = '0;
        ovl_addr  = '0;
        for (int i = 0; i < IDX_VALS; i++)
        begin
            if (pixel_index == pob_pkg::INDEX_W'(i))
            begin
                main_addr = MAIN_AW'(i % MAIN_ENTRIES);
            end
            if (overlay_index == pob_pkg::INDEX_W'(i))
            begin
                ovl_addr = OVL_AW'(i % OVERLAY_ENTRIES);
            end
        end
    end

    always_comb
    begin
        main_wdata.r     = red;
        main_wdata.g     = green;
        main_wdata.b     = blue;
        ovl_wdata.shift  = shift_amount;
        ovl_wdata.r      = red;
        ovl_wdata.g      = green;
        ovl_wdata.b      = blue;
    end

    pob_palette_ram #(
        .DEPTH (MAIN_ENTRIES),
        .WIDTH (pob_pkg::MAIN_W)
    ) u_main_ram (
        .clk   (clk),
        .we    (in_accept && (command == pob_pkg::CMD_LOAD_MAIN)),
        .waddr (main_addr),
        .wdata (main_wdata),
        .re    (in_accept && is_convert),
        .raddr (main_addr),
        .rdata (main_rdata)
    );

    pob_palette_ram #(
        .DEPTH (OVERLAY_ENTRIES),
        .WIDTH (pob_pkg::OVL_W)
    ) u_ovl_ram (
        .clk   (clk),
        .we    (in_accept && (command == pob_pkg::CMD_LOAD_OVL)),
        .waddr (ovl_addr),
        .wdata (ovl_wdata),
        .re    (in_accept && is_convert),
        .raddr (ovl_addr),
        .rdata (ovl_rdata)
    );

    pob_blend u_blend (
        .main_entry     (main_rdata),
        .ovl_entry      (ovl_rdata),
        .overlay_enable (overlay_enable_reg),
        .pixel          (pixel_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlay_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            overlay_enable_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_a_reg <= in_accept && is_convert;
            end
            if (advance_a)
            begin
                out_valid_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance_a && valid_a_reg)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_565 = pixel_reg;

`ifndef SYNTH
    // a load request never occupies the read stage
    a_load_no_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (valid_a_reg == $past(is_convert)))
    else $error("read stage valid does not follow accepted command");

    // read stage moves to the output whenever the output is free
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_a_reg && advance_a) |=> out_valid_reg)
    else $error("read stage result lost");

    // no request taken while both stages are full and stalled
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_a_reg && out_valid_reg && !out_ready) |-> !in_ready)
    else $error("request accepted into a full pipeline");

    // a stalled read stage keeps its request
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_a_reg && !advance_a) |=> valid_a_reg)
    else $error("stalled read stage dropped its request");
`endif

endmodule

/* tb/sv/palette_overlay_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_overlay_pixel_checker: result checker for the pixel blender
// Watches the request, result and config ports. Keeps its own copy of both
// palettes and the overlay switch, predicts each converted pixel in order,
// and compares it with what the block returns.
// ----------------------------------------------------------------------------
module palette_overlay_pixel_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [pob_pkg::CMD_W-1:0]     command,
    input  logic [pob_pkg::INDEX_W-1:0]   pixel_index,
    input  logic [pob_pkg::INDEX_W-1:0]   overlay_index,
    input  logic [pob_pkg::CHAN_W-1:0]    red,
    input  logic [pob_pkg::CHAN_W-1:0]    green,
    input  logic [pob_pkg::CHAN_W-1:0]    blue,
    input  logic [pob_pkg::SHIFT_W-1:0]   shift_amount,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [pob_pkg::PIXEL_W-1:0]   pixel_565,
    output int                            fail_count,
    output int                            pending_count,
    output int                            pixels_checked
);

    pob_pkg::main_entry_t main_lut [16];
    pob_pkg::ovl_entry_t  ovl_lut  [16];
    logic                 overlay_on;

    logic [pob_pkg::PIXEL_W-1:0] pending_pixels [$];
    logic [pob_pkg::PIXEL_W-1:0] want;

    initial
    begin
        fail_count     = 0;
        pending_count  = 0;
        pixels_checked = 0;
        overlay_on     = 1'b0;
    end

    // shifts of eight and up wipe the channel
    function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [3:0] s);
        return (s >= 4'd8) ? 8'd0 : (c >> s);
    endfunction

    function automatic logic [15:0] blend_pixel(
        input pob_pkg::main_entry_t m,
        input pob_pkg::ovl_entry_t  o,
        input logic                 blend
    );
        logic [8:0]  r;
        logic [8:0]  g;
        logic [8:0]  b;
        logic [31:0] word;
        r = {1'b0, m.r};
        g = {1'b0, m.g};
        b = {1'b0, m.b};
        if (blend)
        begin
            r = {1'b0, dim_channel(m.r, o.shift)} + {1'b0, o.r};
            g = {1'b0, dim_channel(m.g, o.shift)} + {1'b0, o.g};
            b = {1'b0, dim_channel(m.b, o.shift)} + {1'b0, o.b};
        end
        // carries out of green and blue land in the field above
        word = (({23'b0, r} & ~32'd7) << 8) | (({23'b0, g} & ~32'd3) << 3)
             | ({23'b0, b} >> 3);
        return word[15:0];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            overlay_on = 1'b0;
            pending_pixels.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel_565 result, expected none, got %h",
                             $time, pixel_565);
                    fail_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (pixel_565 !== want)
                    begin
                        $display("%0t: pixel_565 mismatch, expected %h, got %h",
                                 $time, want, pixel_565);
                        fail_count++;
                    end
                end
            end

            if (cfg_write)
                overlay_on = cfg_data;

            if (in_valid && in_ready)
            begin
                case (command)
                    pob_pkg::CMD_CONVERT:
                        pending_pixels.push_back(blend_pixel(main_lut[pixel_index],
                                                             ovl_lut[overlay_index],
                                                             overlay_on));
                    pob_pkg::CMD_LOAD_MAIN:
                    begin
                        main_lut[pixel_index].r = red;
                        main_lut[pixel_index].g = green;
                        main_lut[pixel_index].b = blue;
                    end
                    pob_pkg::CMD_LOAD_OVL:
                    begin
                        ovl_lut[overlay_index].r     = red;
                        ovl_lut[overlay_index].g     = green;
                        ovl_lut[overlay_index].b     = blue;
                        ovl_lut[overlay_index].shift = shift_amount;
                    end
                    default:
                        ; // dropped request, nothing changes
                endcase
            end
        end
        pending_count = pending_pixels.size();
    end

endmodule

/* tb/sv/palette_overlay_pixel_blender_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_overlay_pixel_blender_tb: top level bench for the pixel blender
// Loads both palettes, converts pixels with the overlay off and on, covers
// full-scale sums, shift wipe-out and dropped requests, then runs random
// phases with stalls on both sides. A side checker judges every pixel.
// ----------------------------------------------------------------------------
module palette_overlay_pixel_blender_tb;

    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_REQS     = 250;
    localparam int NUM_PHASES     = 5;
    localparam logic [1:0] CMD_DROP = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_write     = 1'b0;
    logic        cfg_data      = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  command       = '0;
    logic [3:0]  pixel_index   = '0;
    logic [3:0]  overlay_index = '0;
    logic [7:0]  red           = '0;
    logic [7:0]  green         = '0;
    logic [7:0]  blue          = '0;
    logic [3:0]  shift_amount  = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [15:0] pixel_565;

    int fail_count;
    int pending_count;
    int pixels_checked;

    logic [15:0] main_loaded = '0;
    logic [15:0] ovl_loaded  = '0;
    int n_convert   = 0;
    int n_load_main = 0;
    int n_load_ovl  = 0;
    int n_dropped   = 0;
    int n_settings  = 0;
    int burst_left  = 0;
    int ready_hold  = 0;
    int ready_roll;

    always #5 clk = ~clk;

    palette_overlay_pixel_blender u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .pixel_index   (pixel_index),
        .overlay_index (overlay_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .shift_amount  (shift_amount),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_565     (pixel_565)
    );

    palette_overlay_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .pixel_index    (pixel_index),
        .overlay_index  (overlay_index),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .shift_amount   (shift_amount),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_565      (pixel_565),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .pixels_checked (pixels_checked)
    );

    // receiver: long ready runs now and then, short stalls mostly, a few long ones
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (!out_ready)
            begin
                out_ready  <= 1'b1;
                ready_hold <= (ready_roll < 10) ? $urandom_range(50, 200)
                                                : $urandom_range(0, 15);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_hold <= (ready_roll < 10) ? $urandom_range(15, 40)
                                                : $urandom_range(0, 2);
            end
        end
    end

    // stall watchdog
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int sender_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            burst_left = $urandom_range(30, 120);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_req(
        input logic [1:0] cmd,
        input logic [3:0] pidx,
        input logic [3:0] oidx,
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b,
        input logic [3:0] sh
    );
        int gap;
        in_valid      <= 1'b1;
        command       <= cmd;
        pixel_index   <= pidx;
        overlay_index <= oidx;
        red           <= r;
        green         <= g;
        blue          <= b;
        shift_amount  <= sh;
        do
            @(posedge clk);
        while (!in_ready);
        case (cmd)
            pob_pkg::CMD_CONVERT:   n_convert++;
            pob_pkg::CMD_LOAD_MAIN:
            begin
                n_load_main++;
                main_loaded[pidx] = 1'b1;
            end
            pob_pkg::CMD_LOAD_OVL:
            begin
                n_load_ovl++;
                ovl_loaded[oidx] = 1'b1;
            end
            default:                n_dropped++;
        endcase
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic convert_px(input logic [3:0] pidx, input logic [3:0] oidx);
        send_req(pob_pkg::CMD_CONVERT, pidx, oidx, 8'($urandom), 8'($urandom),
                 8'($urandom), 4'($urandom));
    endtask

    // hold off until the pipeline has handed back every pixel
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_overlay(input logic on);
        cfg_write <= 1'b1;
        cfg_data  <= on;
        @(posedge clk);
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [3:0] pick_loaded(input logic [15:0] mask);
        logic [3:0] idx;
        do
            idx = 4'($urandom_range(0, 15));
        while (!mask[idx]);
        return idx;
    endfunction

    function automatic logic [7:0] rand_chan();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 8'h00;
        if (roll < 20)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [3:0] rand_shift();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 4'd8;
        if (roll < 85)
            return 4'($urandom_range(0, 8));
        return 4'($urandom_range(9, 15));
    endfunction

    initial
    begin
        int done;
        int roll;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // palette extremes, overlay shifts of zero, one, eight and fifteen
        send_req(pob_pkg::CMD_LOAD_MAIN, 4'd0,  4'd9, 8'h00, 8'h00, 8'h00, 4'd0);
        send_req(pob_pkg::CMD_LOAD_MAIN, 4'd15, 4'd6, 8'hFF, 8'hFF, 8'hFF, 4'd15);
        send_req(pob_pkg::CMD_LOAD_MAIN, 4'd5,  4'd0, 8'hAA, 8'h55, 8'hF0, 4'd0);
        send_req(pob_pkg::CMD_LOAD_OVL,  4'd2,  4'd0, 8'h00, 8'h00, 8'h00, 4'd0);
        send_req(pob_pkg::CMD_LOAD_OVL,  4'd7,  4'd15, 8'hFF, 8'hFF, 8'hFF, 4'd15);
        send_req(pob_pkg::CMD_LOAD_OVL,  4'd0,  4'd7, 8'h80, 8'h01, 8'h7F, 4'd8);
        send_req(pob_pkg::CMD_LOAD_OVL,  4'd0,  4'd3, 8'h0F, 8'hF0, 8'h33, 4'd1);
        send_req(pob_pkg::CMD_LOAD_OVL,  4'd0,  4'd1, 8'hFF, 8'hFF, 8'hFF, 4'd0);
        // dropped request must leave the palettes alone
        send_req(CMD_DROP, 4'd15, 4'd1, 8'h12, 8'h34, 8'h56, 4'd3);
        convert_px(4'd0, 4'd0);
        convert_px(4'd15, 4'd15);
        convert_px(4'd5, 4'd7);
        drain_pipe();
        set_overlay(1'b1);
        convert_px(4'd15, 4'd0);
        convert_px(4'd15, 4'd15);
        convert_px(4'd15, 4'd3);
        convert_px(4'd5, 4'd7);
        convert_px(4'd0, 4'd15);
        convert_px(4'd15, 4'd1);  // full-scale sum on every channel
        convert_px(4'd0, 4'd1);
        // load then read the same entry straight away
        send_req(pob_pkg::CMD_LOAD_MAIN, 4'd5, 4'd3, 8'h07, 8'hFC, 8'h1B, 4'd0);
        convert_px(4'd5, 4'd3);
        send_req(pob_pkg::CMD_LOAD_OVL, 4'd5, 4'd3, 8'hF8, 8'h03, 8'hE4, 4'd2);
        convert_px(4'd5, 4'd3);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_pipe();
            set_overlay(phase % 2 == 0 ? 1'b0 : 1'b1);
            done = 0;
            while (done < PHASE_REQS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    send_req(CMD_DROP, 4'($urandom), 4'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 4'($urandom));
                else
                begin
                    if (roll < 18)
                        send_req(pob_pkg::CMD_LOAD_MAIN, 4'($urandom_range(0, 15)),
                                 4'($urandom), rand_chan(), rand_chan(), rand_chan(),
                                 4'($urandom));
                    else if (roll < 33)
                        send_req(pob_pkg::CMD_LOAD_OVL, 4'($urandom),
                                 4'($urandom_range(0, 15)), rand_chan(), rand_chan(),
                                 rand_chan(), rand_shift());
                    else
                        convert_px(pick_loaded(main_loaded), pick_loaded(ovl_loaded));
                    done++;
                end
            end
        end

        drain_pipe();
        $display("%0d requests: %0d conversions, %0d main loads, %0d overlay loads, %0d dropped",
                 n_convert + n_load_main + n_load_ovl + n_dropped, n_convert, n_load_main,
                 n_load_ovl, n_dropped);
        $display("%0d pixels compared over %0d overlay switch writes",
                 pixels_checked, n_settings);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* palette_overlay_pixel_blender.f */
rtl/pob_pkg.sv
rtl/pob_palette_ram.sv
rtl/pob_blend.sv
rtl/palette_overlay_pixel_blender.sv
tb/sv/palette_overlay_pixel_checker.sv
tb/sv/palette_overlay_pixel_blender_tb.sv
